### sv/distance_constraint_projection_macros.svh
// assertion macros shared by the distance constraint projection checkers
`ifndef DISTANCE_CONSTRAINT_PROJECTION_MACROS_SVH
`define DISTANCE_CONSTRAINT_PROJECTION_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcp port check failed");

// next-cycle implication, disabled while reset is asserted
`define DCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcp port check failed");

`endif

### sv/dcp_pkg.sv
// shared widths and transaction types of the distance constraint projection
package dcp_pkg;

  localparam int unsigned COORD_W       = 32;
  localparam int unsigned MASS_W        = 24;
  localparam int unsigned REST_W        = 31;
  localparam int unsigned DIFF_W        = COORD_W + 1;
  localparam int unsigned ROOT_W        = COORD_W + 2;
  localparam int unsigned SQR_W         = 2 * ROOT_W;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned HALF_W        = WORD_W / 2;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_a_x;
    logic signed [COORD_W-1:0] pos_a_y;
    logic signed [COORD_W-1:0] pos_a_z;
    logic signed [COORD_W-1:0] pos_b_x;
    logic signed [COORD_W-1:0] pos_b_y;
    logic signed [COORD_W-1:0] pos_b_z;
    logic [MASS_W-1:0]         inv_mass_a;
    logic [MASS_W-1:0]         inv_mass_b;
    logic [REST_W-1:0]         rest_length;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_a_x;
    logic signed [COORD_W-1:0] new_a_y;
    logic signed [COORD_W-1:0] new_a_z;
    logic signed [COORD_W-1:0] new_b_x;
    logic signed [COORD_W-1:0] new_b_y;
    logic signed [COORD_W-1:0] new_b_z;
    logic                      degenerate;
  } out_t;

endpackage

### sv/dcp_sqrt.sv
// pipelined integer square root, one root bit per stage
module dcp_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [dcp_pkg::SQR_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [dcp_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int unsigned NST   = dcp_pkg::ROOT_W;
  localparam int unsigned REM_W = NST + 2;
  localparam int unsigned TRY_W = REM_W + 2;

  logic                      valid_q [NST];
  logic [REM_W-1:0]          rem_q   [NST];
  logic [NST-1:0]            root_q  [NST];
  logic [dcp_pkg::SQR_W-1:0] rad_q   [NST];
  logic [SIDE_W-1:0]         side_q  [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic                      v_in;
    logic [REM_W-1:0]          rem_in;
    logic [NST-1:0]            root_in;
    logic [dcp_pkg::SQR_W-1:0] rad_in;
    logic [SIDE_W-1:0]         side_in;
    logic [TRY_W-1:0]          trial;
    logic [TRY_W-1:0]          cand;
    logic [TRY_W-1:0]          diff;
    logic                      take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign trial = {rem_in, rad_in[dcp_pkg::SQR_W-1 -: 2]};
    assign cand  = {2'b00, root_in, 2'b01};
    assign take  = trial >= cand;
    assign diff  = trial - cand;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
        root_q[k] <= {root_in[NST-2:0], take};
        rad_q[k]  <= rad_in << 2;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NST-1];
  assign root_o  = root_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

### sv/dcp_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
module dcp_div #(
  parameter int unsigned NUM_W  = 50,
  parameter int unsigned DEN_W  = 34,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q [NUM_W];
  logic [DEN_W-1:0]  rem_q   [NUM_W];
  logic [NUM_W-1:0]  num_q   [NUM_W];
  logic [NUM_W-1:0]  quo_q   [NUM_W];
  logic [DEN_W-1:0]  den_q   [NUM_W];
  logic [SIDE_W-1:0] side_q  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  num_in;
    logic [NUM_W-1:0]  quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign num_in  = num_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign take  = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_q[k]  <= num_in << 1;
        quo_q[k]  <= {quo_in[NUM_W-2:0], take};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NUM_W-1];
  assign quo_o   = quo_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

### sv/dcp_out_buf.sv
// two-entry result buffer between the pipeline and the output channel
module dcp_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dcp_pkg::out_t data_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output dcp_pkg::out_t data_o
);

  logic [1:0]    cnt_q, cnt_d;
  logic          wr_q, rd_q;
  logic          pop;
  dcp_pkg::out_t mem_q [2];

  assign valid_o = cnt_q != 2'd0;
  assign space_o = cnt_q != 2'd2;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### sv/distance_constraint_projection.sv
// top level of the distance constraint projection pipeline
// Distance constraint projection: takes one spring constraint (particles A and B,
// their inverse masses and a rest length) per transaction and returns both
// corrected positions plus a degenerate flag. The datapath is a fully pipelined
// chain: difference and squares (4 stages), a square root that resolves one root
// bit per stage (34 stages), the length error (1 stage), three restoring dividers
// that each resolve one quotient bit per stage (34 + FRAC_BITS stages for the
// ratio, 24 + FRAC_BITS stages for each mass share), split 32-bit partial-product
// multiplies (4 stages) and a final saturating add into a two-entry output buffer.
// A new transaction is taken every cycle while in_ready_o is high. in_ready_o
// drops only when the output buffer holds two results, and the whole pipeline
// then holds still until one of them is taken.
module distance_constraint_projection #(
  parameter int unsigned FRAC_BITS = dcp_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dcp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dcp_pkg::out_t out_data_o
);

  localparam int unsigned COORD_W = dcp_pkg::COORD_W;
  localparam int unsigned DIFF_W  = dcp_pkg::DIFF_W;
  localparam int unsigned ROOT_W  = dcp_pkg::ROOT_W;
  localparam int unsigned WORD_W  = dcp_pkg::WORD_W;
  localparam int unsigned HALF_W  = dcp_pkg::HALF_W;
  localparam int unsigned MASS_W  = dcp_pkg::MASS_W;
  localparam int unsigned WS_W    = MASS_W + 1;             // mass sum
  localparam int unsigned E_W     = ROOT_W + 1;             // signed length error
  localparam int unsigned TQ_W    = ROOT_W + FRAC_BITS;     // ratio magnitude
  localparam int unsigned T_W     = TQ_W + 1;               // signed ratio
  localparam int unsigned MN_W    = MASS_W + FRAC_BITS;     // mass share numerator
  localparam int unsigned M_W     = FRAC_BITS + 1;          // mass share, at most one

  // per-item data that rides along the long pipeline stretches
  typedef struct packed {
    logic [2:0][COORD_W-1:0] a;
    logic [2:0][COORD_W-1:0] b;
    logic [2:0][DIFF_W-1:0]  d;
    logic [MASS_W-1:0]       wa;
    logic [MASS_W-1:0]       wb;
    logic [WS_W-1:0]         wsum;
    logic [dcp_pkg::REST_W-1:0] rest;
  } base_t;

  typedef struct packed {
    base_t base;
    logic  neg;
    logic  degen;
  } tside_t;

  typedef struct packed {
    base_t          base;
    logic [T_W-1:0] t;
    logic           degen;
  } mside_t;

  typedef struct packed {
    base_t          base;
    logic [T_W-1:0] t;
    logic           degen;
    logic [M_W-1:0] ma;
  } bside_t;

  typedef struct packed {
    base_t          base;
    logic [M_W-1:0] ma;
    logic [M_W-1:0] mb;
    logic           degen;
  } carry_t;

  // signed divide by 2^FRAC_BITS, rounding toward zero
  function automatic logic [WORD_W-1:0] trunc_shift(input logic [WORD_W-1:0] p);
    logic [WORD_W-1:0] bias;
    bias = p[WORD_W-1] ? ((WORD_W'(1) << FRAC_BITS) - WORD_W'(1)) : '0;
    return WORD_W'($signed(p + bias) >>> FRAC_BITS);
  endfunction

  // clamp a signed word to the coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [WORD_W-1:0] v);
    logic [WORD_W-COORD_W:0] hi;
    hi = v[WORD_W-1:COORD_W-1];
    if ((&hi) || !(|hi)) begin
      return v[COORD_W-1:0];
    end else if (v[WORD_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // global advance: every stage moves unless the output buffer is full
  logic en;
  logic buf_space;
  assign en         = buf_space;
  assign in_ready_o = en;

  // ---------------------------------------------------------------- stage 1
  // register the incoming transaction
  logic         v1_q;
  dcp_pkg::in_t in1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in1_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // per-axis difference b - a, its magnitude, and the mass sum
  base_t                   base2_d, base2_q;
  logic [2:0][COORD_W-1:0] abs2_d, abs2_q;
  logic                    v2_q;

  always_comb begin
    base2_d.a    = {in1_q.pos_a_z, in1_q.pos_a_y, in1_q.pos_a_x};
    base2_d.b    = {in1_q.pos_b_z, in1_q.pos_b_y, in1_q.pos_b_x};
    base2_d.wa   = in1_q.inv_mass_a;
    base2_d.wb   = in1_q.inv_mass_b;
    base2_d.wsum = WS_W'(in1_q.inv_mass_a) + WS_W'(in1_q.inv_mass_b);
    base2_d.rest = in1_q.rest_length;
    for (int i = 0; i < 3; i++) begin
      base2_d.d[i] = DIFF_W'($signed(base2_d.b[i])) - DIFF_W'($signed(base2_d.a[i]));
      // magnitude never exceeds 2^32 - 1
      abs2_d[i] = base2_d.d[i][DIFF_W-1] ? COORD_W'(-base2_d.d[i])
                                         : COORD_W'(base2_d.d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      base2_q <= base2_d;
      abs2_q  <= abs2_d;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // squares, one 32x32 multiplier per axis
  logic [2:0][2*COORD_W-1:0] sq3_d, sq3_q;
  base_t                     base3_q;
  logic                      v3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq3_d[i] = abs2_q[i] * abs2_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq3_q   <= sq3_d;
      base3_q <= base2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // squared distance, exact
  logic [dcp_pkg::SQR_W-1:0] rad4_d, rad4_q;
  base_t                     base4_q;
  logic                      v4_q;

  assign rad4_d = dcp_pkg::SQR_W'(sq3_q[0]) + dcp_pkg::SQR_W'(sq3_q[1])
                + dcp_pkg::SQR_W'(sq3_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad4_q  <= rad4_d;
      base4_q <= base3_q;
    end
  end

  // ---------------------------------------------------------------- distance
  logic              v5;
  logic [ROOT_W-1:0] root5;
  base_t             base5;

  dcp_sqrt #(
    .SIDE_W ($bits(base_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .rad_i   (rad4_q),
    .side_i  (base4_q),
    .valid_o (v5),
    .root_o  (root5),
    .side_o  (base5)
  );

  // ---------------------------------------------------------------- stage 6
  // length error as sign and magnitude, degenerate detection
  logic signed [E_W-1:0] e6;
  logic [ROOT_W-1:0]     emag6;
  logic                  v6_q;
  logic [TQ_W-1:0]       num6_q;
  logic [ROOT_W-1:0]     den6_q;
  tside_t                tside6_d, tside6_q;

  assign e6    = $signed(E_W'(root5) - E_W'(base5.rest));
  assign emag6 = e6[E_W-1] ? ROOT_W'(-e6) : ROOT_W'(e6);

  always_comb begin
    tside6_d.base  = base5;
    tside6_d.neg   = e6[E_W-1];
    tside6_d.degen = (root5 == '0) || (base5.wsum == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num6_q   <= {emag6, {FRAC_BITS{1'b0}}};
      den6_q   <= root5;
      tside6_q <= tside6_d;
    end
  end

  // ---------------------------------------------------------------- ratio
  // (dist - rest) * 2^F / dist
  logic            v7;
  logic [TQ_W-1:0] quo7;
  tside_t          tside7;
  logic [T_W-1:0]  t7;
  mside_t          mside7;

  dcp_div #(
    .NUM_W  (TQ_W),
    .DEN_W  (ROOT_W),
    .SIDE_W ($bits(tside_t))
  ) u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .num_i   (num6_q),
    .den_i   (den6_q),
    .side_i  (tside6_q),
    .valid_o (v7),
    .quo_o   (quo7),
    .side_o  (tside7)
  );

  assign t7 = tside7.neg ? (T_W'(0) - T_W'(quo7)) : T_W'(quo7);

  always_comb begin
    mside7.base  = tside7.base;
    mside7.t     = t7;
    mside7.degen = tside7.degen;
  end

  // ---------------------------------------------------------------- mass shares
  // wa * 2^F / wsum, then wb * 2^F / wsum
  logic            v8;
  logic [MN_W-1:0] quoa8;
  mside_t          mside8;
  bside_t          bside8;

  dcp_div #(
    .NUM_W  (MN_W),
    .DEN_W  (WS_W),
    .SIDE_W ($bits(mside_t))
  ) u_div_ma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7),
    .num_i   ({tside7.base.wa, {FRAC_BITS{1'b0}}}),
    .den_i   (tside7.base.wsum),
    .side_i  (mside7),
    .valid_o (v8),
    .quo_o   (quoa8),
    .side_o  (mside8)
  );

  always_comb begin
    bside8.base  = mside8.base;
    bside8.t     = mside8.t;
    bside8.degen = mside8.degen;
    bside8.ma    = quoa8[M_W-1:0];
  end

  logic            v9;
  logic [MN_W-1:0] quob9;
  bside_t          bside9;

  dcp_div #(
    .NUM_W  (MN_W),
    .DEN_W  (WS_W),
    .SIDE_W ($bits(bside_t))
  ) u_div_mb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8),
    .num_i   ({mside8.base.wb, {FRAC_BITS{1'b0}}}),
    .den_i   (mside8.base.wsum),
    .side_i  (bside8),
    .valid_o (v9),
    .quo_o   (quob9),
    .side_o  (bside9)
  );

  // ---------------------------------------------------------------- stage m1
  // d * t as 64-bit wrapping product, split into 32-bit partial products
  logic [2:0][WORD_W-1:0] ppl10_d, ppl10_q;
  logic [2:0][HALF_W-1:0] pph10_d, pph10_q;
  logic [2:0][HALF_W-1:0] ppx10_d, ppx10_q;
  carry_t                 c10_d, c10_q;
  logic                   v10_q;

  always_comb begin
    logic [WORD_W-1:0] dd;
    logic [WORD_W-1:0] tt;
    tt = WORD_W'($signed(bside9.t));
    for (int i = 0; i < 3; i++) begin
      dd         = WORD_W'($signed(bside9.base.d[i]));
      ppl10_d[i] = dd[HALF_W-1:0] * tt[HALF_W-1:0];
      pph10_d[i] = dd[HALF_W-1:0] * tt[WORD_W-1:HALF_W];
      ppx10_d[i] = dd[WORD_W-1:HALF_W] * tt[HALF_W-1:0];
    end
    c10_d.base  = bside9.base;
    c10_d.ma    = bside9.ma;
    c10_d.mb    = quob9[M_W-1:0];
    c10_d.degen = bside9.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else if (en) begin
      v10_q <= v9;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ppl10_q <= ppl10_d;
      pph10_q <= pph10_d;
      ppx10_q <= ppx10_d;
      c10_q   <= c10_d;
    end
  end

  // ---------------------------------------------------------------- stage m2
  // u = (d * t) / 2^F
  logic [2:0][WORD_W-1:0] u11_d, u11_q;
  carry_t                 c11_q;
  logic                   v11_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u11_d[i] = trunc_shift(ppl10_q[i] + {pph10_q[i] + ppx10_q[i], {HALF_W{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q <= 1'b0;
    end else if (en) begin
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u11_q <= u11_d;
      c11_q <= c10_q;
    end
  end

  // ---------------------------------------------------------------- stage m3
  // u * ma and u * mb, partial products of the low and high halves of u
  logic [2:0][WORD_W-1:0] qal12_d, qal12_q, qbl12_d, qbl12_q;
  logic [2:0][HALF_W-1:0] qah12_d, qah12_q, qbh12_d, qbh12_q;
  carry_t                 c12_q;
  logic                   v12_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qal12_d[i] = u11_q[i][HALF_W-1:0] * c11_q.ma;
      qah12_d[i] = u11_q[i][WORD_W-1:HALF_W] * c11_q.ma;
      qbl12_d[i] = u11_q[i][HALF_W-1:0] * c11_q.mb;
      qbh12_d[i] = u11_q[i][WORD_W-1:HALF_W] * c11_q.mb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v12_q <= 1'b0;
    end else if (en) begin
      v12_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qal12_q <= qal12_d;
      qah12_q <= qah12_d;
      qbl12_q <= qbl12_d;
      qbh12_q <= qbh12_d;
      c12_q   <= c11_q;
    end
  end

  // ---------------------------------------------------------------- stage m4
  // corrections for a and b
  logic [2:0][WORD_W-1:0] ca13_d, ca13_q, cb13_d, cb13_q;
  carry_t                 c13_q;
  logic                   v13_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca13_d[i] = trunc_shift(qal12_q[i] + {qah12_q[i], {HALF_W{1'b0}}});
      cb13_d[i] = trunc_shift(qbl12_q[i] + {qbh12_q[i], {HALF_W{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v13_q <= 1'b0;
    end else if (en) begin
      v13_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ca13_q <= ca13_d;
      cb13_q <= cb13_d;
      c13_q  <= c12_q;
    end
  end

  // ---------------------------------------------------------------- stage m5
  // apply corrections with saturation, or pass through when degenerate
  logic [2:0][COORD_W-1:0] na14, nb14;
  dcp_pkg::out_t           res14;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (c13_q.degen) begin
        na14[i] = c13_q.base.a[i];
        nb14[i] = c13_q.base.b[i];
      end else begin
        na14[i] = sat_coord(WORD_W'($signed(c13_q.base.a[i])) + ca13_q[i]);
        nb14[i] = sat_coord(WORD_W'($signed(c13_q.base.b[i])) - cb13_q[i]);
      end
    end
    res14.new_a_x    = na14[0];
    res14.new_a_y    = na14[1];
    res14.new_a_z    = na14[2];
    res14.new_b_x    = nb14[0];
    res14.new_b_y    = nb14[1];
    res14.new_b_z    = nb14[2];
    res14.degenerate = c13_q.degen;
  end

  dcp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v13_q && en),
    .data_i  (res14),
    .space_o (buf_space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

### sv/dcp_checker.sv
// port-level checks for the distance constraint projection, bound to the top level
`include "distance_constraint_projection_macros.svh"

module dcp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input dcp_pkg::out_t out_data_o
);

  // a waiting result is neither dropped nor altered
  `DCP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // input is only held off while results are waiting
  `DCP_ASSERT_IMP(a_stall_has_result, clk_i, rst_ni, !in_ready_o, out_valid_o)

  // backpressure on the input only follows an untaken result
  `DCP_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_o, $past(out_valid_o && !out_ready_i))

endmodule

bind distance_constraint_projection dcp_checker u_dcp_checker (.*);
